/* sv/ovl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

  localparam int PAIR_SLOTS = 32;
  localparam int SLOT_W     = $clog2(PAIR_SLOTS);
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_BASE  = 2'd0,
    CFG_LINK_BASE  = 2'd1,
    CFG_TEXT_BYTES = 2'd2,
    CFG_DATA_BYTES = 2'd3
  } cfg_reg_t;

  // Section field of a relocation entry.
  typedef enum logic [1:0] {
    SECT_ABS  = 2'd0,
    SECT_TEXT = 2'd1,
    SECT_DATA = 2'd2,
    SECT_BSS  = 2'd3
  } sect_t;

  // Relocation type codes.
  localparam logic [5:0] RTYPE_32   = 6'd2;
  localparam logic [5:0] RTYPE_26   = 6'd4;
  localparam logic [5:0] RTYPE_HI16 = 6'd5;
  localparam logic [5:0] RTYPE_LO16 = 6'd6;

  // Section bases and the relocation delta, derived from the registers.
  typedef struct packed {
    logic [31:0] load_base;
    logic [31:0] data_base;
    logic [31:0] bss_base;
    logic [31:0] delta;
  } bases_t;

  // One memory write.
  typedef struct packed {
    logic [31:0] address;
    logic [31:0] data;
    logic        last;
  } wr_t;

  // Contents of one HI16 pairing slot.
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] upper;
    logic [15:0] orig_lo;
    logic [15:0] cur_lo;
  } slot_t;

  // Update of one pairing slot.
  typedef struct packed {
    logic              set_all;
    logic              set_cur;
    logic [SLOT_W-1:0] slot;
    slot_t             value;
  } slot_wr_t;

endpackage

`default_nettype wire

/* sv/ovl_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module ovl_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [ovl_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [31:0]                    wr_data,
  output ovl_pkg::bases_t                     bases
);

  logic [31:0] load_r, load_nxt;
  logic [31:0] link_r, link_nxt;
  logic [23:0] text_r, text_nxt;
  logic [23:0] data_r, data_nxt;
  ovl_pkg::bases_t bases_r, bases_nxt;

  always_comb begin
    load_nxt = load_r;
    link_nxt = link_r;
    text_nxt = text_r;
    data_nxt = data_r;
    if (wr_en) begin
      unique case (ovl_pkg::cfg_reg_t'(wr_index))
        ovl_pkg::CFG_LOAD_BASE:  load_nxt = wr_data;
        ovl_pkg::CFG_LINK_BASE:  link_nxt = wr_data;
        ovl_pkg::CFG_TEXT_BYTES: text_nxt = wr_data[23:0];
        ovl_pkg::CFG_DATA_BYTES: data_nxt = wr_data[23:0];
        default: ;
      endcase
    end
  end

  // Bases are registered and follow the registers in the next cycle.
  always_comb begin
    bases_nxt.load_base = load_r;
    bases_nxt.data_base = load_r + {8'd0, text_r};
    bases_nxt.bss_base  = load_r + ({8'd0, text_r} + {8'd0, data_r});
    bases_nxt.delta     = load_r - link_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r  <= '0;
      link_r  <= '0;
      text_r  <= '0;
      data_r  <= '0;
      bases_r <= '0;
    end else begin
      load_r  <= load_nxt;
      link_r  <= link_nxt;
      text_r  <= text_nxt;
      data_r  <= data_nxt;
      bases_r <= bases_nxt;
    end
  end

  assign bases = bases_r;

endmodule

`default_nettype wire

/* sv/ovl_slots.sv */
`timescale 1ns / 1ps
`default_nettype none

module ovl_slots (
  input  wire logic                        clk,
  input  wire ovl_pkg::slot_wr_t           wr,
  input  wire logic [ovl_pkg::SLOT_W-1:0]  rd_slot,
  output ovl_pkg::slot_t                   rd
);

  logic [31:0] address_r [ovl_pkg::PAIR_SLOTS];
  logic [15:0] upper_r   [ovl_pkg::PAIR_SLOTS];
  logic [15:0] orig_lo_r [ovl_pkg::PAIR_SLOTS];
  logic [15:0] cur_lo_r  [ovl_pkg::PAIR_SLOTS];

  // Contents are undefined until a HI16 entry writes the slot.
  always_ff @(posedge clk) begin
    if (wr.set_all) begin
      address_r[wr.slot] <= wr.value.address;
      upper_r[wr.slot]   <= wr.value.upper;
      orig_lo_r[wr.slot] <= wr.value.orig_lo;
      cur_lo_r[wr.slot]  <= wr.value.cur_lo;
    end else if (wr.set_cur) begin
      cur_lo_r[wr.slot]  <= wr.value.cur_lo;
    end
  end

  always_comb begin
    rd.address = address_r[rd_slot];
    rd.upper   = upper_r[rd_slot];
    rd.orig_lo = orig_lo_r[rd_slot];
    rd.cur_lo  = cur_lo_r[rd_slot];
  end

endmodule

`default_nettype wire

/* sv/ovl_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

module ovl_calc (
  input  wire logic [31:0]                 entry,
  input  wire logic [31:0]                 word,
  input  wire ovl_pkg::bases_t             bases,
  input  wire ovl_pkg::slot_t              rd,
  output logic [ovl_pkg::SLOT_W-1:0]       rd_slot,
  output logic [1:0]                       n_wr,
  output ovl_pkg::wr_t                     wr0,
  output ovl_pkg::wr_t                     wr1,
  output ovl_pkg::slot_wr_t                slot_wr
);

  logic [31:0] base;
  logic [31:0] addr;
  logic [31:0] ptr_reb;
  logic [31:0] jmp_reb;
  logic [31:0] lo_sext;
  logic [15:0] chk_hi;
  logic [31:0] rel;
  logic [15:0] half;
  logic [5:0]  rtype;

  always_comb begin
    unique case (ovl_pkg::sect_t'(entry[31:30]))
      ovl_pkg::SECT_ABS:  base = '0;
      ovl_pkg::SECT_TEXT: base = bases.load_base;
      ovl_pkg::SECT_DATA: base = bases.data_base;
      ovl_pkg::SECT_BSS:  base = bases.bss_base;
      default:            base = '0;
    endcase
  end

  assign addr    = base + {8'd0, entry[23:0]};
  assign rtype   = entry[29:24];
  assign rd_slot = word[25:21];

  assign ptr_reb = word + bases.delta;
  // Jump target placed in KSEG0 before relocation.
  assign jmp_reb = {4'b1000, word[25:0], 2'b00} + bases.delta;

  // The LO16 pairing: the upper half of (hi << 16) + sext(lo) for the check,
  // and the recorded hi plus sext(lo), moved by the current delta, for the
  // new address.
  assign lo_sext = {{16{word[15]}}, word[15:0]};
  assign chk_hi  = rd.cur_lo + {16{word[15]}};
  assign rel     = {rd.orig_lo, 16'd0} + lo_sext + bases.delta;
  assign half    = rel[31:16] + {15'd0, rel[15]};

  always_comb begin
    n_wr                  = 2'd0;
    wr0                   = '{address: addr, data: ptr_reb, last: 1'b1};
    wr1                   = '{address: addr, data: {word[31:16], rel[15:0]}, last: 1'b1};
    slot_wr.set_all       = 1'b0;
    slot_wr.set_cur       = 1'b0;
    slot_wr.slot          = rd_slot;
    slot_wr.value.address = addr;
    slot_wr.value.upper   = word[31:16];
    slot_wr.value.orig_lo = word[15:0];
    slot_wr.value.cur_lo  = word[15:0];
    unique case (rtype)
      ovl_pkg::RTYPE_32: begin
        // Words with bits 27:24 set are not pointers into the overlay.
        if (word[27:24] == 4'd0) begin
          n_wr = 2'd1;
        end
      end
      ovl_pkg::RTYPE_26: begin
        n_wr     = 2'd1;
        wr0.data = {word[31:26], jmp_reb[27:2]};
      end
      ovl_pkg::RTYPE_HI16: begin
        slot_wr.set_all = 1'b1;
        slot_wr.slot    = word[20:16];
      end
      ovl_pkg::RTYPE_LO16: begin
        if (chk_hi[11:8] == 4'd0) begin
          n_wr                 = 2'd2;
          wr0.address          = rd.address;
          wr0.data             = {rd.upper, half};
          wr0.last             = 1'b0;
          slot_wr.set_cur      = 1'b1;
          slot_wr.value.cur_lo = half;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/ovl_outbuf.sv */
`timescale 1ns / 1ps
`default_nettype none

module ovl_outbuf (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire logic [1:0] n_wr,
  input  wire ovl_pkg::wr_t wr0,
  input  wire ovl_pkg::wr_t wr1,
  output logic        room,
  output logic        out_valid,
  input  wire logic   out_stall,
  output ovl_pkg::wr_t head
);

  logic [1:0]   cnt_r, cnt_nxt;
  ovl_pkg::wr_t q0_r, q0_nxt;
  ovl_pkg::wr_t q1_r, q1_nxt;
  logic         pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  // A new group is taken only when the buffer drains by this edge.
  assign room      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall);
  assign head      = q0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (push && (n_wr != 2'd0)) begin
      cnt_nxt = n_wr;
      q0_nxt  = wr0;
      q1_nxt  = wr1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      q0_nxt  = q1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

`default_nettype wire

/* sv/mips_overlay_relocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// MIPS overlay relocator. Each input transfer carries one relocation entry
// (section, type and byte offset) with the word currently stored at its
// location, and the block answers with zero, one or two memory writes that
// patch the loaded overlay: one write for a 32-bit pointer or a 26-bit jump
// target, none for a HI16 entry (it is only remembered, in one of 32 slots
// picked by the LUI's rt field), and two for a LO16 entry, first the paired
// LUI word and then the LO16 word itself, with last_write set on the final
// write of the entry. Pointers with bits 27:24 set, LO16 pairs that fail the
// range check, and unknown types produce no write. An entry sits in the input
// register, where all arithmetic is done, before its writes enter a two-deep
// output buffer. The block takes a new entry every cycle while the write side
// keeps up; a LO16 entry fills the single write channel with two writes, so
// the entry after it cannot enter the buffer before the second is taken.
// Configuration registers take effect only once section bases and the
// relocation delta, which are precomputed into registers, follow them; the
// port is always ready and must only be written while no entry is in flight.
// A LO16 whose HI16 slot was never written returns undefined data.
module mips_overlay_relocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ovl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [31:0]                    in_reloc_entry,
  input  wire logic [31:0]                    in_target_word,
  input  wire logic                           in_last_entry,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [31:0]                         out_write_address,
  output logic [31:0]                         out_write_data,
  output logic                                out_last_write
);

  ovl_pkg::bases_t   bases;
  ovl_pkg::slot_t    slot_rd;
  ovl_pkg::slot_wr_t slot_wr_raw;
  ovl_pkg::slot_wr_t slot_wr;
  ovl_pkg::wr_t      wr0;
  ovl_pkg::wr_t      wr1;
  ovl_pkg::wr_t      head;
  logic [ovl_pkg::SLOT_W-1:0] rd_slot;
  logic [1:0]  n_wr;
  logic        room;
  logic        adv;
  logic        in_xfer;

  // Input register: one entry under evaluation.
  logic        s1_v_r, s1_v_nxt;
  logic [31:0] entry_r;
  logic [31:0] word_r;

  assign cfg_ready = 1'b1;

  ovl_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .bases    (bases)
  );

  ovl_calc u_calc (
    .entry   (entry_r),
    .word    (word_r),
    .bases   (bases),
    .rd      (slot_rd),
    .rd_slot (rd_slot),
    .n_wr    (n_wr),
    .wr0     (wr0),
    .wr1     (wr1),
    .slot_wr (slot_wr_raw)
  );

  // The entry leaves the input register when its writes fit in the buffer;
  // entries without writes leave at once. Slot updates happen on that edge,
  // so the following entry already sees them.
  assign adv      = s1_v_r && ((n_wr == 2'd0) || room);
  assign in_stall = s1_v_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    slot_wr         = slot_wr_raw;
    slot_wr.set_all = slot_wr_raw.set_all && adv;
    slot_wr.set_cur = slot_wr_raw.set_cur && adv;
  end

  ovl_slots u_slots (
    .clk     (clk),
    .wr      (slot_wr),
    .rd_slot (rd_slot),
    .rd      (slot_rd)
  );

  ovl_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .n_wr      (n_wr),
    .wr0       (wr0),
    .wr1       (wr1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // The last-entry flag does not change any write, so it is not kept.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      entry_r <= in_reloc_entry;
      word_r  <= in_target_word;
    end
  end

  assign out_write_address = head.address;
  assign out_write_data    = head.data;
  assign out_last_write    = head.last;

endmodule

`default_nettype wire

/* dv/reloc_write_checker.sv */
`timescale 1ns / 1ps

// Watches the register port, the entry channel and the write channel of the
// relocator. It keeps its own copy of the registers and of the HI16 pairing
// slots, predicts the writes for every accepted entry and compares each
// write transfer with the oldest predicted one.
module reloc_write_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ovl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [31:0]                   in_reloc_entry,
  input  logic [31:0]                   in_target_word,
  input  logic                          in_last_entry,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [31:0]                   out_write_address,
  input  logic [31:0]                   out_write_data,
  input  logic                          out_last_write,
  output int                            fail_count,
  output int                            writes_pending
);

  logic [31:0] load_base;
  logic [31:0] link_base;
  logic [23:0] text_bytes;
  logic [23:0] data_bytes;

  logic [31:0] lui_address [ovl_pkg::PAIR_SLOTS];
  logic [31:0] lui_first   [ovl_pkg::PAIR_SLOTS];
  logic [31:0] lui_latest  [ovl_pkg::PAIR_SLOTS];

  ovl_pkg::wr_t writes_due[$];
  int           mismatches = 0;

  initial begin
    fail_count     = 0;
    writes_pending = 0;
  end

  function automatic logic [31:0] rebase(input logic [31:0] a);
    return a - link_base + load_base;
  endfunction

  function automatic void expect_write(input logic [31:0] a, input logic [31:0] d,
                                       input logic l);
    ovl_pkg::wr_t w;
    w.address = a;
    w.data    = d;
    w.last    = l;
    writes_due.push_back(w);
  endfunction

  task automatic predict_writes(input logic [31:0] entry, input logic [31:0] word);
    logic [31:0] base;
    logic [31:0] addr;
    logic [31:0] lo;
    logic [31:0] probe;
    logic [31:0] rel;
    logic [31:0] tgt;
    logic [15:0] half;
    logic [4:0]  s;
    case (ovl_pkg::sect_t'(entry[31:30]))
      ovl_pkg::SECT_ABS:  base = 32'h0;
      ovl_pkg::SECT_TEXT: base = load_base;
      ovl_pkg::SECT_DATA: base = load_base + {8'h0, text_bytes};
      default:            base = load_base + {8'h0, text_bytes} + {8'h0, data_bytes};
    endcase
    addr = base + {8'h0, entry[23:0]};
    case (entry[29:24])
      ovl_pkg::RTYPE_32: begin
        if (word[27:24] == 4'h0) expect_write(addr, rebase(word), 1'b1);
      end
      ovl_pkg::RTYPE_26: begin
        tgt = rebase({4'b1000, word[25:0], 2'b00});
        expect_write(addr, {word[31:26], tgt[27:2]}, 1'b1);
      end
      ovl_pkg::RTYPE_HI16: begin
        s = word[20:16];
        lui_address[s] = addr;
        lui_first[s]   = word;
        lui_latest[s]  = word;
      end
      ovl_pkg::RTYPE_LO16: begin
        s     = word[25:21];
        lo    = {{16{word[15]}}, word[15:0]};
        probe = {lui_latest[s][15:0], 16'h0} + lo;
        if (probe[27:24] == 4'h0) begin
          rel           = rebase({lui_first[s][15:0], 16'h0} + lo);
          half          = rel[31:16] + {15'h0, rel[15]};
          lui_latest[s] = {lui_latest[s][31:16], half};
          expect_write(lui_address[s], lui_latest[s], 1'b0);
          expect_write(addr, {word[31:16], rel[15:0]}, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ovl_pkg::wr_t w;
    if (!rst_n) begin
      load_base  = 32'h0;
      link_base  = 32'h0;
      text_bytes = 24'h0;
      data_bytes = 24'h0;
      writes_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (writes_due.size() == 0) begin
          $error("write to %h (data %h) with no write expected",
                 out_write_address, out_write_data);
          mismatches++;
        end else begin
          w = writes_due.pop_front();
          if (out_write_address !== w.address) begin
            $error("write_address: expected %h, got %h", w.address, out_write_address);
            mismatches++;
          end
          if (out_write_data !== w.data) begin
            $error("write_data: expected %h, got %h", w.data, out_write_data);
            mismatches++;
          end
          if (out_last_write !== w.last) begin
            $error("last_write: expected %b, got %b", w.last, out_last_write);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (ovl_pkg::cfg_reg_t'(cfg_index))
          ovl_pkg::CFG_LOAD_BASE:  load_base  = cfg_data;
          ovl_pkg::CFG_LINK_BASE:  link_base  = cfg_data;
          ovl_pkg::CFG_TEXT_BYTES: text_bytes = cfg_data[23:0];
          ovl_pkg::CFG_DATA_BYTES: data_bytes = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_writes(in_reloc_entry, in_target_word);
    end
    writes_pending <= writes_due.size();
    fail_count     <= mismatches;
  end

endmodule

/* dv/mips_overlay_relocator_tb.sv */
`timescale 1ns / 1ps

// Top of the relocator testbench. It owns the clock and reset, writes the
// four section/base registers between traffic phases, feeds relocation
// entries and drives backpressure on the write channel. All prediction and
// comparison live in reloc_write_checker, which sits beside the block and
// reports its failure count and the number of writes still outstanding.
module mips_overlay_relocator_tb;

  // Type codes the block does not handle, used for the lowest and highest
  // values of the type field.
  localparam logic [5:0] RTYPE_NONE = 6'h00;
  localparam logic [5:0] RTYPE_TOP  = 6'h3F;

  localparam int N_PHASES       = 8;
  localparam int FIRST_RANDOM   = 100;
  localparam int RAND_PER_PHASE = 175;
  // An entry passes the input register and the output buffer before its first
  // write appears, so DRAIN_CYCLES after the last expected write nothing can
  // still be in flight, not even an entry that produces no write.
  localparam int DRAIN_CYCLES   = 6;
  // Section bases are precomputed into registers after a register write.
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int LIMIT_CYCLES   = 500000;

  logic        clk;
  logic        rst_n;

  logic        cfg_valid;
  logic        cfg_ready;
  logic [ovl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_reloc_entry;
  logic [31:0] in_target_word;
  logic        in_last_entry;

  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_write_address;
  logic [31:0] out_write_data;
  logic        out_last_write;

  // The write side stalls either for its per-transfer random wait or for the
  // one long hold-off; the two come from separate processes.
  logic        rx_stall;
  logic        hold_stall;
  logic        hold_kick;
  assign out_stall = rx_stall | hold_stall;

  // Set for phases that run back to back with no idle cycles on either side.
  logic        no_idle;
  // HI16 slots that have been written at least once. A LO16 entry is only
  // ever pointed at one of these, since an unwritten slot has no defined value.
  logic [ovl_pkg::PAIR_SLOTS-1:0] slot_live;

  int          fail_count;
  int          writes_pending;
  int          cycle_count;

  mips_overlay_relocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_reloc_entry    (in_reloc_entry),
    .in_target_word    (in_target_word),
    .in_last_entry     (in_last_entry),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_last_write    (out_last_write)
  );

  reloc_write_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_reloc_entry    (in_reloc_entry),
    .in_target_word    (in_target_word),
    .in_last_entry     (in_last_entry),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_last_write    (out_last_write),
    .fail_count        (fail_count),
    .writes_pending    (writes_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs or loses writes.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] mk_entry(input ovl_pkg::sect_t sec,
                                           input logic [5:0] kind,
                                           input logic [23:0] off);
    return {sec, kind, off};
  endfunction

  // Offers one entry after a random number of idle cycles and returns right
  // after the edge that completes its transfer. The valid stays high when the
  // next entry follows with no gap, so it is never dropped and raised again in
  // the same step.
  task automatic send_item(input logic [31:0] entry, input logic [31:0] word,
                           input logic last);
    int          gap;
    logic [31:0] w;
    logic [4:0]  s;
    w = word;
    if (entry[29:24] == ovl_pkg::RTYPE_LO16 && !slot_live[w[25:21]]) begin
      do s = 5'($urandom); while (!slot_live[s]);
      w[25:21] = s;
    end
    if (entry[29:24] == ovl_pkg::RTYPE_HI16) slot_live[w[20:16]] = 1'b1;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_reloc_entry <= entry;
    in_target_word <= w;
    in_last_entry  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the register port's valid high across consecutive writes; the
  // caller lowers it after the last one.
  task automatic put_reg(input ovl_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stops offering entries and waits until every predicted write has been
  // seen, then lets the pipeline empty of entries that write nothing.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write side: before every write it stalls for a random wait, with none in
  // no_idle phases, then waits, unstalled, for the next write transfer.
  initial begin
    int k;
    rx_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      k = no_idle ? 0 : $urandom_range(0, 9);
      if (k != 0) begin
        rx_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      rx_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // One long hold-off on the write side. The sender keeps offering entries
  // with no gaps meanwhile, so the output buffer fills and the block has to
  // stall its input.
  initial begin
    hold_stall <= 1'b0;
    wait (hold_kick);
    @(posedge clk);
    hold_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_stall <= 1'b0;
  end

  initial begin
    logic [31:0] load_v;
    logic [31:0] link_v;
    logic [23:0] text_v;
    logic [23:0] data_v;
    logic [31:0] word;
    logic [15:0] imm;
    logic [5:0]  kind;
    logic [4:0]  s;
    int          sent;
    int          target;
    int          pick;
    int          reps;

    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= ovl_pkg::CFG_LOAD_BASE;
    cfg_data       <= 32'h0;
    in_valid       <= 1'b0;
    in_reloc_entry <= 32'h0;
    in_target_word <= 32'h0;
    in_last_entry  <= 1'b0;
    hold_kick      <= 1'b0;
    no_idle        = 1'b0;
    slot_live      = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) quiesce();

      // Register settings per phase: a typical overlay first, then the
      // all-zero and all-ones extremes, two mixed extremes, and random ones
      // where the link address sits just below the load address.
      case (ph)
        0: begin
          load_v = 32'h8040_0000; link_v = 32'h8000_0000;
          text_v = 24'h00_1230;   data_v = 24'h00_0400;
        end
        1: begin
          load_v = 32'h0; link_v = 32'h0; text_v = 24'h0; data_v = 24'h0;
        end
        2: begin
          load_v = 32'hFFFF_FFFF; link_v = 32'hFFFF_FFFF;
          text_v = 24'hFF_FFFF;   data_v = 24'hFF_FFFF;
        end
        3: begin
          load_v = 32'h0; link_v = 32'hFFFF_FFFF; text_v = 24'hFF_FFFF; data_v = 24'h0;
        end
        4: begin
          load_v = 32'hFFFF_FFFF; link_v = 32'h0; text_v = 24'h0; data_v = 24'hFF_FFFF;
        end
        default: begin
          load_v = $urandom;
          link_v = load_v - $urandom_range(0, 32'h00FF_FFFF);
          text_v = 24'($urandom);
          data_v = 24'($urandom);
        end
      endcase
      put_reg(ovl_pkg::CFG_LOAD_BASE, load_v);
      put_reg(ovl_pkg::CFG_LINK_BASE, link_v);
      put_reg(ovl_pkg::CFG_TEXT_BYTES, {8'h0, text_v});
      put_reg(ovl_pkg::CFG_DATA_BYTES, {8'h0, data_v});
      cfg_valid <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clk);

      no_idle = (ph == 2 || ph == 6);
      if (ph == 2) hold_kick <= 1'b1;

      if (ph == 0) begin
        // Pointers: a plain one, one at the largest offset, all-ones outside
        // bits 27:24, and two with bits 27:24 set, which are left alone.
        send_item(mk_entry(ovl_pkg::SECT_ABS, ovl_pkg::RTYPE_32, 24'h00_0000),
                  32'h8000_1234, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_TEXT, ovl_pkg::RTYPE_32, 24'hFF_FFFF),
                  32'h0000_0000, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_DATA, ovl_pkg::RTYPE_32, 24'h00_0010),
                  32'hF0FF_FFFF, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_BSS, ovl_pkg::RTYPE_32, 24'h00_0020),
                  32'h0F00_0000, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_BSS, ovl_pkg::RTYPE_32, 24'h00_0024),
                  32'h8100_0000, 1'b0);
        // Jump targets with an all-zero and an all-ones field.
        send_item(mk_entry(ovl_pkg::SECT_TEXT, ovl_pkg::RTYPE_26, 24'h00_0100),
                  32'h0C00_0000, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_BSS, ovl_pkg::RTYPE_26, 24'hFF_FFFC),
                  32'hFFFF_FFFF, 1'b1);
        // A HI16 in slot 0 followed by two LO16 entries that use it; the
        // second one sees the LUI word as rewritten by the first.
        send_item(mk_entry(ovl_pkg::SECT_TEXT, ovl_pkg::RTYPE_HI16, 24'h00_0200),
                  32'h3C00_8040, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_TEXT, ovl_pkg::RTYPE_LO16, 24'h00_0204),
                  32'h2404_1234, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_TEXT, ovl_pkg::RTYPE_LO16, 24'h00_0208),
                  32'h8C05_FFF0, 1'b0);
        // Slot 31: a negative low half borrows into bits 27:24, so the range
        // check fails and nothing is written.
        send_item(mk_entry(ovl_pkg::SECT_DATA, ovl_pkg::RTYPE_HI16, 24'h00_0300),
                  32'h3C1F_0000, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_DATA, ovl_pkg::RTYPE_LO16, 24'h00_0304),
                  32'h27E0_8000, 1'b0);
        // Slot 31 rewritten; an all-ones low half exercises the rounding of
        // the upper half.
        send_item(mk_entry(ovl_pkg::SECT_DATA, ovl_pkg::RTYPE_HI16, 24'h00_0308),
                  32'h3C1F_0001, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_DATA, ovl_pkg::RTYPE_LO16, 24'h00_030C),
                  32'h27E0_FFFF, 1'b1);
        // Slot 5 holds a LUI immediate with bits 11:8 set: check fails.
        send_item(mk_entry(ovl_pkg::SECT_BSS, ovl_pkg::RTYPE_HI16, 24'h00_0400),
                  32'h3C05_0F00, 1'b0);
        send_item(mk_entry(ovl_pkg::SECT_BSS, ovl_pkg::RTYPE_LO16, 24'h00_0404),
                  32'h24A0_0000, 1'b0);
        // Types the block ignores, at both ends of the type field.
        send_item(mk_entry(ovl_pkg::SECT_ABS, RTYPE_NONE, 24'hFF_FFFF),
                  32'hFFFF_FFFF, 1'b1);
        send_item(mk_entry(ovl_pkg::SECT_BSS, RTYPE_TOP, 24'h00_0000),
                  32'h0000_0000, 1'b1);
      end

      // Random traffic. Most of it is HI16/LO16 sequences sharing one slot,
      // with the LUI immediate mostly kept clear of bits 11:8 so that the
      // range check passes; the rest is pointers, jumps, stray HI16 and LO16
      // entries, and fully random entries. Ignored types do not count.
      target = (ph == 0) ? FIRST_RANDOM : RAND_PER_PHASE;
      sent   = 0;
      while (sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          s   = 5'($urandom);
          imm = 16'($urandom);
          if ($urandom_range(0, 3) != 0) imm[11:8] = 4'h0;
          word = {6'($urandom), 5'($urandom), s, imm};
          send_item(mk_entry(ovl_pkg::sect_t'($urandom_range(0, 3)), ovl_pkg::RTYPE_HI16,
                             24'($urandom)),
                    word, 1'($urandom));
          reps = $urandom_range(1, 3);
          repeat (reps) begin
            word = {6'($urandom), s, 5'($urandom), 16'($urandom)};
            send_item(mk_entry(ovl_pkg::sect_t'($urandom_range(0, 3)), ovl_pkg::RTYPE_LO16,
                               24'($urandom)),
                      word, 1'($urandom));
          end
          sent += reps + 1;
        end else if (pick < 50) begin
          word = $urandom;
          if ($urandom_range(0, 4) != 0) word[27:24] = 4'h0;
          send_item(mk_entry(ovl_pkg::sect_t'($urandom_range(0, 3)), ovl_pkg::RTYPE_32,
                             24'($urandom)),
                    word, 1'($urandom));
          sent++;
        end else if (pick < 65) begin
          send_item(mk_entry(ovl_pkg::sect_t'($urandom_range(0, 3)), ovl_pkg::RTYPE_26,
                             24'($urandom)),
                    $urandom, 1'($urandom));
          sent++;
        end else if (pick < 75) begin
          send_item(mk_entry(ovl_pkg::sect_t'($urandom_range(0, 3)), ovl_pkg::RTYPE_HI16,
                             24'($urandom)),
                    $urandom, 1'($urandom));
          sent++;
        end else if (pick < 85) begin
          send_item(mk_entry(ovl_pkg::sect_t'($urandom_range(0, 3)), ovl_pkg::RTYPE_LO16,
                             24'($urandom)),
                    $urandom, 1'($urandom));
          sent++;
        end else begin
          word = $urandom;
          kind = 6'($urandom);
          send_item({2'($urandom), kind, 24'($urandom)}, word, 1'($urandom));
          if (kind == ovl_pkg::RTYPE_32 || kind == ovl_pkg::RTYPE_26 ||
              kind == ovl_pkg::RTYPE_HI16 || kind == ovl_pkg::RTYPE_LO16)
            sent++;
        end
      end
    end

    quiesce();
    if (fail_count == 0 && writes_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
